FILE: src/mec_pkg.sv
// ----------------------------------------------------------------------------
// mec_pkg
// Shared types and constants for the mesh edge isoline crossing block.
// ----------------------------------------------------------------------------
package mec_pkg;

    // Per-level step of the level numerator, 2 * 65536 * 9998.
    localparam logic [30:0] D_STEP    = 31'd1310457856;
    // Twice the level denominator per unit of (levels - 1).
    localparam logic [20:0] DEN2_UNIT = 21'd20000;
    // Starting remainder per unit of (levels - 1).
    localparam logic [16:0] R0_UNIT   = 17'd1072;
    // Level 0 in Q16.16 when there are two or more levels.
    localparam logic [16:0] LVL_FIRST = 17'd7;
    // The single level 0.9999 in Q16.16.
    localparam logic [16:0] LVL_SOLO  = 17'd65529;

    localparam int DIV_STEPS = 32;
    // Register stages of one interpolation lane, input to output.
    localparam int LANE_LAT  = DIV_STEPS + 4;

    typedef struct packed {
        logic       valid;
        logic [5:0] idx;
        logic       bnd;
        logic       last;
    } t_meta;

endpackage

FILE: src/mec_lerp_lane.sv
// ----------------------------------------------------------------------------
// mec_lerp_lane
// One coordinate of the crossing point: p0 + num * (p1 - p0) / d, rounded
// half away from zero and saturated, through a pipelined restoring divider.
// ----------------------------------------------------------------------------
module mec_lerp_lane (
    input  logic               i_clk,
    input  logic        [31:0] i_num,
    input  logic        [31:0] i_d,
    input  logic signed [31:0] i_p0,
    input  logic signed [31:0] i_p1,
    output logic signed [31:0] o_point
);

    localparam int NS = mec_pkg::DIV_STEPS;

    logic        [31:0] r1_num, r1_d;
    logic signed [31:0] r1_p0, r1_p1;
    logic        [31:0] r2_num, r2_d, r2_mag;
    logic signed [31:0] r2_p0;
    logic               r2_neg;
    logic signed [32:0] w_delta;

    logic        [31:0] r_rem [0:NS];
    logic        [31:0] r_lo  [0:NS];
    logic        [31:0] r_quo [0:NS];
    logic        [31:0] r_dd  [0:NS];
    logic signed [31:0] r_p0s [0:NS];
    logic               r_neg [0:NS];

    logic        [32:0] w_qr;
    logic signed [34:0] w_res;
    logic               w_up;

    assign w_delta = 33'(r1_p1) - 33'(r1_p0);

    always_ff @(posedge i_clk) begin
        r1_num <= i_num;
        r1_d   <= i_d;
        r1_p0  <= i_p0;
        r1_p1  <= i_p1;

        r2_num <= r1_num;
        r2_d   <= r1_d;
        r2_p0  <= r1_p0;
        r2_neg <= w_delta[32];
        r2_mag <= w_delta[32] ? 32'(-w_delta) : 32'(w_delta);

        {r_rem[0], r_lo[0]} <= 64'(r2_num) * 64'(r2_mag);
        r_quo[0] <= '0;
        r_dd[0]  <= r2_d;
        r_p0s[0] <= r2_p0;
        r_neg[0] <= r2_neg;
    end

    for (genvar j = 0; j < NS; j++) begin : g_div
        logic [32:0] w_trial;
        logic        w_ge;
        assign w_trial = {r_rem[j], r_lo[j][31]};
        assign w_ge    = w_trial >= {1'b0, r_dd[j]};
        always_ff @(posedge i_clk) begin
            r_rem[j+1] <= w_ge ? 32'(w_trial - {1'b0, r_dd[j]}) : w_trial[31:0];
            r_lo[j+1]  <= {r_lo[j][30:0], 1'b0};
            r_quo[j+1] <= {r_quo[j][30:0], w_ge};
            r_dd[j+1]  <= r_dd[j];
            r_p0s[j+1] <= r_p0s[j];
            r_neg[j+1] <= r_neg[j];
        end
    end

    // Round up when twice the remainder reaches the divisor.
    assign w_up  = {r_rem[NS], 1'b0} >= {1'b0, r_dd[NS]};
    assign w_qr  = 33'(r_quo[NS]) + 33'(w_up);
    assign w_res = r_neg[NS] ? 35'(r_p0s[NS]) - $signed({2'b00, w_qr})
                             : 35'(r_p0s[NS]) + $signed({2'b00, w_qr});

    always_ff @(posedge i_clk) begin
        if (r_dd[NS] == '0) begin
            o_point <= r_p0s[NS];
        end else if (w_res > 35'sd2147483647) begin
            o_point <= 32'sh7FFFFFFF;
        end else if (w_res < -35'sd2147483648) begin
            o_point <= 32'sh80000000;
        end else begin
            o_point <= 32'(w_res);
        end
    end

endmodule

FILE: src/mesh_edge_isoline_crossing.sv
// The level walk issues one level per cycle into a 36-stage interpolation pipeline
// and takes no new edge until it has issued every level of the current one.
// After reset and after each num_levels write, busy stays high while a bit-serial
// divider derives the level step; results flow without stalls.
// ----------------------------------------------------------------------------
// mesh_edge_isoline_crossing
// Orders the edge endpoints by scalar, walks the iso levels in ascending
// order and interpolates the crossing point for each level in range.
// ----------------------------------------------------------------------------
module mesh_edge_isoline_crossing #(
    parameter int MAX_LEVELS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic        [6:0]  i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_scalar_a,
    input  logic signed [31:0] i_scalar_b,
    input  logic signed [31:0] i_a_x,
    input  logic signed [31:0] i_a_y,
    input  logic signed [31:0] i_a_z,
    input  logic signed [31:0] i_b_x,
    input  logic signed [31:0] i_b_y,
    input  logic signed [31:0] i_b_z,
    input  logic               i_a_on_boundary,
    input  logic               i_b_on_boundary,
    output logic               o_valid,
    output logic        [5:0]  o_level_index,
    output logic signed [31:0] o_point_x,
    output logic signed [31:0] o_point_y,
    output logic signed [31:0] o_point_z,
    output logic               o_boundary_edge,
    output logic               o_last
);

    localparam int LAT = mec_pkg::LANE_LAT;

    logic [6:0]  r_num_levels;
    logic [6:0]  w_ne;
    logic [5:0]  w_nm1;
    logic [20:0] w_den2;
    logic [16:0] w_r0;

    // Level step calibration
    logic        r_cal_busy;
    logic [4:0]  r_cal_cnt;
    logic [21:0] r_cal_rem;
    logic [15:0] r_cal_quo;
    logic [30:0] w_dstep;
    logic [21:0] w_cal_trial;
    logic        w_cal_ge;

    // Level walk
    logic               r_run;
    logic [6:0]         r_k;
    logic [16:0]        r_lq;
    logic [20:0]        r_lr;
    logic signed [31:0] r_s0, r_s1;
    logic signed [31:0] r_p0 [0:2];
    logic signed [31:0] r_p1 [0:2];
    logic               r_bnd;

    logic [21:0]        w_rs;
    logic               w_carry;
    logic [17:0]        w_nq;
    logic signed [31:0] w_lvl;
    logic               w_cross, w_lastk, w_is_last, w_swap;
    logic [31:0]        w_num, w_d;

    mec_pkg::t_meta r_meta [0:LAT-1];
    mec_pkg::t_meta w_meta_in;
    logic signed [31:0] w_pt [0:2];

    assign w_ne = (r_num_levels == 7'd0) ? 7'd1 :
                  (r_num_levels > 7'(MAX_LEVELS)) ? 7'(MAX_LEVELS) : r_num_levels;
    assign w_nm1  = 6'(w_ne - 7'd1);
    assign w_den2 = 21'(w_nm1) * mec_pkg::DEN2_UNIT;
    assign w_r0   = 17'(w_nm1) * mec_pkg::R0_UNIT;

    assign w_dstep     = mec_pkg::D_STEP;
    assign w_cal_trial = {r_cal_rem[20:0], w_dstep[5'd30 - r_cal_cnt]};
    assign w_cal_ge    = w_cal_trial >= {1'b0, w_den2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_levels <= 7'd10;
            r_cal_busy   <= 1'b1;
            r_cal_cnt    <= '0;
            r_cal_rem    <= '0;
        end else if (i_cfg_we) begin
            r_num_levels <= i_cfg_wdata;
            r_cal_busy   <= 1'b1;
            r_cal_cnt    <= '0;
            r_cal_rem    <= '0;
        end else if (r_cal_busy) begin
            r_cal_rem  <= w_cal_ge ? 22'(w_cal_trial - {1'b0, w_den2}) : w_cal_trial;
            r_cal_quo  <= {r_cal_quo[14:0], w_cal_ge};
            r_cal_cnt  <= 5'(r_cal_cnt + 5'd1);
            if (r_cal_cnt == 5'd30) begin
                r_cal_busy <= 1'b0;
            end
        end
    end

    assign busy = r_run | r_cal_busy;

    // Next level: add the fixed step and carry the remainder once.
    assign w_rs      = 22'(r_lr) + 22'(r_cal_rem[20:0]);
    assign w_carry   = w_rs >= {1'b0, w_den2};
    assign w_nq      = 18'(r_lq) + 18'(r_cal_quo) + 18'(w_carry);
    assign w_lvl     = $signed({15'b0, r_lq});
    assign w_cross   = r_run && (w_lvl >= r_s0) && (w_lvl <= r_s1);
    assign w_lastk   = r_k == 7'(w_ne - 7'd1);
    assign w_is_last = w_lastk || ($signed({14'b0, w_nq}) > r_s1);
    assign w_num     = 32'(w_lvl - r_s0);
    assign w_d       = 32'(r_s1 - r_s0);
    assign w_swap    = i_scalar_a > i_scalar_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (start && !busy) begin
            r_run   <= 1'b1;
            r_k     <= '0;
            r_lq    <= (w_ne == 7'd1) ? mec_pkg::LVL_SOLO : mec_pkg::LVL_FIRST;
            r_lr    <= 21'(w_r0);
            r_bnd   <= i_a_on_boundary & i_b_on_boundary;
            r_s0    <= w_swap ? i_scalar_b : i_scalar_a;
            r_s1    <= w_swap ? i_scalar_a : i_scalar_b;
            r_p0[0] <= w_swap ? i_b_x : i_a_x;
            r_p0[1] <= w_swap ? i_b_y : i_a_y;
            r_p0[2] <= w_swap ? i_b_z : i_a_z;
            r_p1[0] <= w_swap ? i_a_x : i_b_x;
            r_p1[1] <= w_swap ? i_a_y : i_b_y;
            r_p1[2] <= w_swap ? i_a_z : i_b_z;
        end else if (r_run) begin
            r_k  <= 7'(r_k + 7'd1);
            r_lq <= 17'(w_nq);
            r_lr <= w_carry ? 21'(w_rs - {1'b0, w_den2}) : 21'(w_rs);
            if (w_lastk) begin
                r_run <= 1'b0;
            end
        end
    end

    for (genvar c = 0; c < 3; c++) begin : g_lane
        mec_lerp_lane u_lane (
            .i_clk   (i_clk),
            .i_num   (w_num),
            .i_d     (w_d),
            .i_p0    (r_p0[c]),
            .i_p1    (r_p1[c]),
            .o_point (w_pt[c])
        );
    end

    assign w_meta_in = '{valid: w_cross, idx: r_k[5:0], bnd: r_bnd, last: w_is_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LAT; i++) begin
                r_meta[i].valid <= 1'b0;
            end
        end else begin
            r_meta[0] <= w_meta_in;
            for (int i = 1; i < LAT; i++) begin
                r_meta[i] <= r_meta[i-1];
            end
        end
    end

    assign o_valid         = r_meta[LAT-1].valid;
    assign o_level_index   = r_meta[LAT-1].idx;
    assign o_boundary_edge = r_meta[LAT-1].bnd;
    assign o_last          = r_meta[LAT-1].valid & r_meta[LAT-1].last;
    assign o_point_x       = w_pt[0];
    assign o_point_y       = w_pt[1];
    assign o_point_z       = w_pt[2];

endmodule

FILE: src/mec_checker.sv
// ----------------------------------------------------------------------------
// mec_checker
// Port-level checks on the isoline crossing block, bound to its top level.
// ----------------------------------------------------------------------------
module mec_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic       start,
    input logic       busy,
    input logic       o_valid,
    input logic [5:0] o_level_index,
    input logic       o_boundary_edge,
    input logic       o_last
);

    // An accepted edge raises busy right after the transfer; only that first step is checked.
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low right after an edge transfer");

    // A register write starts the level step calibration.
    a_busy_after_cfg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("busy low right after a configuration write");

    // Crossings of one edge come in consecutive cycles at consecutive levels.
    a_levels_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=>
            (o_valid && o_level_index == 6'($past(o_level_index) + 6'd1)))
        else $error("crossing sequence broken before its last transfer");

    // The boundary flag is one value for all crossings of an edge.
    a_bnd_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> (o_boundary_edge == $past(o_boundary_edge)))
        else $error("boundary flag changed within one edge");

endmodule

bind mesh_edge_isoline_crossing mec_checker u_mec_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_cfg_we        (i_cfg_we),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_level_index   (o_level_index),
    .o_boundary_edge (o_boundary_edge),
    .o_last          (o_last)
);
